>>> rtl/core/tlbpt_pkg.sv
package tlbpt_pkg;

   localparam int ADDR_WIDTH   = 16;
   localparam int PAGE_BYTES   = 256;
   localparam int PAGE_COUNT   = 256;
   localparam int FRAME_COUNT  = 256;
   localparam int OFFSET_WIDTH = $clog2(PAGE_BYTES);
   localparam int PAGE_WIDTH   = $clog2(PAGE_COUNT);
   localparam int FRAME_WIDTH  = $clog2(FRAME_COUNT);
   localparam int FREE_WIDTH   = FRAME_WIDTH + 1;
   localparam int COUNT_WIDTH  = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};
   localparam logic [FREE_WIDTH-1:0]  FREE_LIMIT = FREE_WIDTH'(FRAME_COUNT);

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]  phys_addr;
      logic [FRAME_WIDTH-1:0] frame_index;
      logic                   tlb_hit;
      logic                   page_fault;
      logic                   frames_exhausted;
      logic [COUNT_WIDTH-1:0] hit_total;
      logic [COUNT_WIDTH-1:0] fault_total;
   } rsp_payload_type;

endpackage

>>> rtl/core/tlbpt_channels.sv
interface tlbpt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] virt_addr;

   modport source (output valid, output virt_addr, input ready);
   modport sink (input valid, input virt_addr, output ready);
endinterface

interface tlbpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] phys_addr;
   logic [7:0]  frame_index;
   logic        tlb_hit;
   logic        page_fault;
   logic        frames_exhausted;
   logic [15:0] hit_total;
   logic [15:0] fault_total;

   modport source (
      output valid, output phys_addr, output frame_index, output tlb_hit,
      output page_fault, output frames_exhausted, output hit_total, output fault_total,
      input ready
   );
   modport sink (
      input valid, input phys_addr, input frame_index, input tlb_hit,
      input page_fault, input frames_exhausted, input hit_total, input fault_total,
      output ready
   );
endinterface

>>> rtl/core/tlbpt_ctrl.sv
module tlbpt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tlbpt_pkg::cmd_type cmd
);
   import tlbpt_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/tlbpt_datapath.sv
module tlbpt_datapath #(
   parameter int TLB_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tlbpt_pkg::cmd_type         cmd,
   input  logic [15:0]                virt_addr,
   output tlbpt_pkg::rsp_payload_type rsp_payload
);
   import tlbpt_pkg::*;

   localparam int TLB_INDEX_WIDTH = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam logic [TLB_INDEX_WIDTH-1:0] TLB_LAST = TLB_INDEX_WIDTH'(TLB_ENTRIES - 1);

   logic [ADDR_WIDTH-1:0]      addr_ff;
   logic [PAGE_WIDTH-1:0]      page;
   logic [OFFSET_WIDTH-1:0]    offset;
   logic [PAGE_WIDTH-1:0]      req_page;

   logic [TLB_ENTRIES-1:0]     tlb_valid_ff;
   logic [PAGE_WIDTH-1:0]      tlb_page_ff [TLB_ENTRIES];
   logic [FRAME_WIDTH-1:0]     tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_INDEX_WIDTH-1:0] fill_ff, fill_in;

   logic [PAGE_COUNT-1:0]      map_valid_ff;
   logic [FRAME_WIDTH-1:0]     map_mem [PAGE_COUNT];
   logic [FRAME_WIDTH-1:0]     map_rd_ff;

   logic [FREE_WIDTH-1:0]      free_ff, free_in;
   logic [COUNT_WIDTH-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [COUNT_WIDTH-1:0]     fault_cnt_ff, fault_cnt_in;
   rsp_payload_type            rsp_ff, rsp_in;

   logic                       tlb_hit;
   logic [FRAME_WIDTH-1:0]     tlb_frame_sel;
   logic [FRAME_WIDTH-1:0]     frame;
   logic                       fault;
   logic                       exhausted;
   logic                       refill;
   logic                       map_we;

   assign req_page = virt_addr[ADDR_WIDTH-1 -: PAGE_WIDTH];
   assign page     = addr_ff[ADDR_WIDTH-1 -: PAGE_WIDTH];
   assign offset   = addr_ff[OFFSET_WIDTH-1:0];

   // The lowest-numbered matching entry wins.
   always_comb begin
      tlb_hit       = 1'b0;
      tlb_frame_sel = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && (tlb_page_ff[i] == page)) begin
            tlb_hit       = 1'b1;
            tlb_frame_sel = tlb_frame_ff[i];
         end
      end
   end

   always_comb begin
      frame        = '0;
      fault        = 1'b0;
      exhausted    = 1'b0;
      refill       = 1'b0;
      map_we       = 1'b0;
      free_in      = free_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (tlb_hit) begin
         frame = tlb_frame_sel;
         if (hit_cnt_ff != COUNT_MAX) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end
      end else if (map_valid_ff[page]) begin
         frame  = map_rd_ff;
         refill = 1'b1;
      end else begin
         fault = 1'b1;
         if (fault_cnt_ff != COUNT_MAX) begin
            fault_cnt_in = fault_cnt_ff + 1'b1;
         end
         if (free_ff < FREE_LIMIT) begin
            frame   = free_ff[FRAME_WIDTH-1:0];
            free_in = free_ff + 1'b1;
            map_we  = 1'b1;
            refill  = 1'b1;
         end else begin
            exhausted = 1'b1;
         end
      end
   end

   always_comb begin
      fill_in = (fill_ff == TLB_LAST) ? '0 : fill_ff + 1'b1;
   end

   always_comb begin
      rsp_in.phys_addr        = exhausted ? '0 : {frame, offset};
      rsp_in.frame_index      = frame;
      rsp_in.tlb_hit          = tlb_hit;
      rsp_in.page_fault       = fault;
      rsp_in.frames_exhausted = exhausted;
      rsp_in.hit_total        = hit_cnt_in;
      rsp_in.fault_total      = fault_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff   <= virt_addr;
         map_rd_ff <= map_mem[req_page];
      end
      if (cmd.commit && map_we) begin
         map_mem[page] <= frame;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && refill) begin
         tlb_page_ff[fill_ff]  <= page;
         tlb_frame_ff[fill_ff] <= frame;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff <= '0;
         fill_ff      <= '0;
         map_valid_ff <= '0;
         free_ff      <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
      end else if (cmd.commit) begin
         free_ff      <= free_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         if (refill) begin
            tlb_valid_ff[fill_ff] <= 1'b1;
            fill_ff               <= fill_in;
         end
         if (map_we) begin
            map_valid_ff[page] <= 1'b1;
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/tlb_page_table_translator.sv
// Channel   Direction  Payload                                       Handshake
// req_chan  in         virt_addr                                     valid/ready
// rsp_chan  out        phys_addr, frame_index, tlb_hit,              valid/ready
//                      page_fault, frames_exhausted, hit_total,
//                      fault_total
//
// Each address is first accepted, with a read of the page table memory, and
// then compared against the TLB and resolved into a translation.
// A finished transaction sits in the output register, so the next request is
// accepted while it waits; the resolve cycle stalls only if that register is
// still full. Reset is synchronous and clears all valid bits and counters.
module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = 16
) (
   input logic         clock,
   input logic         reset,
   tlbpt_req_if.sink   req_chan,
   tlbpt_rsp_if.source rsp_chan
);
   import tlbpt_pkg::*;

   cmd_type         cmd;
   rsp_payload_type rsp_payload;

   tlbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   tlbpt_datapath #(
      .TLB_ENTRIES (TLB_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .virt_addr   (req_chan.virt_addr),
      .rsp_payload (rsp_payload)
   );

   assign rsp_chan.phys_addr        = rsp_payload.phys_addr;
   assign rsp_chan.frame_index      = rsp_payload.frame_index;
   assign rsp_chan.tlb_hit          = rsp_payload.tlb_hit;
   assign rsp_chan.page_fault       = rsp_payload.page_fault;
   assign rsp_chan.frames_exhausted = rsp_payload.frames_exhausted;
   assign rsp_chan.hit_total        = rsp_payload.hit_total;
   assign rsp_chan.fault_total      = rsp_payload.fault_total;

   // A request is never taken back to back.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a lookup is in progress");

   // Running out of frames is a page fault with a zero address.
   a_exhausted_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frames_exhausted) |->
         (rsp_chan.page_fault && !rsp_chan.tlb_hit && (rsp_chan.phys_addr == '0)))
      else $error("frames exhausted without a clean page fault");

   // A reported hit is already counted.
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.tlb_hit) |-> (rsp_chan.hit_total != '0))
      else $error("TLB hit reported with a zero hit count");

   // A reported fault is already counted, and never coincides with a hit.
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.page_fault) |->
         ((rsp_chan.fault_total != '0) && !rsp_chan.tlb_hit))
      else $error("page fault reported inconsistently");

endmodule
